// ===== src/bsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit-set bank package
// Shared sizes, opcodes, command types and bit-search helpers for the bit-set
// bank with find-first/find-last.
// ----------------------------------------------------------------------------
package bsb_pkg;

  localparam int NUM_SETS      = 4;
  localparam int WORDS_PER_SET = 16;
  localparam int WORD_BITS     = 64;
  localparam int TOTAL_WORDS   = NUM_SETS * WORDS_PER_SET;
  localparam int BITS_PER_SET  = WORDS_PER_SET * WORD_BITS;

  localparam int OPCODE_W    = 3;
  localparam int SET_W       = 2;
  localparam int BIT_INDEX_W = 10;
  localparam int POS_W       = 10;

  localparam int ADDR_W     = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
  localparam int WORD_IDX_W = (WORDS_PER_SET > 1) ? $clog2(WORDS_PER_SET) : 1;
  localparam int BIT_POS_W  = $clog2(WORD_BITS);

  localparam int QUEUE_DEPTH = 2;

  // Request opcodes; the two remaining codes are rejected.
  typedef enum logic [OPCODE_W-1:0] {
    OP_SET       = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_TEST      = 3'd2,
    OP_FIND_LOW  = 3'd3,
    OP_FIND_HIGH = 3'd4,
    OP_DISJOINT  = 3'd5
  } opcode_t;

  // Classified command handed from the front end to the back end.
  typedef enum logic [2:0] {
    CMD_SET,
    CMD_CLEAR,
    CMD_TEST,
    CMD_FIND_LOW,
    CMD_FIND_HIGH,
    CMD_DISJOINT,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [SET_W-1:0]      set_a;
    logic [SET_W-1:0]      set_b;
    logic [WORD_IDX_W-1:0] word;
    logic [BIT_POS_W-1:0]  bit_pos;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN
  } back_state_t;

  function automatic logic [ADDR_W-1:0] word_addr(input logic [SET_W-1:0] set_num,
                                                  input logic [WORD_IDX_W-1:0] word);
    return ADDR_W'(int'(set_num) * WORDS_PER_SET + int'(word));
  endfunction

  // Binary search for the lowest set bit; the word must not be zero.
  function automatic logic [BIT_POS_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] v;
    logic [BIT_POS_W-1:0] p;
    int                   step;
    v = w;
    p = '0;
    for (int l = BIT_POS_W - 1; l >= 0; l--) begin
      step = 1 << l;
      if ((v & ((WORD_BITS'(1) << step) - WORD_BITS'(1))) == '0) begin
        p[l] = 1'b1;
        v    = v >> step;
      end
    end
    return p;
  endfunction

  // Binary search for the highest set bit; the word must not be zero.
  function automatic logic [BIT_POS_W-1:0] highest_set(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] v;
    logic [BIT_POS_W-1:0] p;
    int                   step;
    v = w;
    p = '0;
    for (int l = BIT_POS_W - 1; l >= 0; l--) begin
      step = 1 << l;
      if ((v >> step) != '0) begin
        p[l] = 1'b1;
        v    = v >> step;
      end
    end
    return p;
  endfunction

endpackage

// ===== src/bsb_if.sv =====
// ----------------------------------------------------------------------------
// Bit-set bank channel interfaces
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface bsb_req_if;
  logic                             valid;
  logic                             ready;
  logic [bsb_pkg::OPCODE_W-1:0]     opcode;
  logic [bsb_pkg::SET_W-1:0]        set_a;
  logic [bsb_pkg::SET_W-1:0]        set_b;
  logic [bsb_pkg::BIT_INDEX_W-1:0]  bit_index;

  modport source (output valid, opcode, set_a, set_b, bit_index, input ready);
  modport sink   (input valid, opcode, set_a, set_b, bit_index, output ready);
endinterface

interface bsb_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       flag;
  logic                       found;
  logic [bsb_pkg::POS_W-1:0]  position;
  logic                       error;

  modport source (output valid, flag, found, position, error, input ready);
  modport sink   (input valid, flag, found, position, error, output ready);
endinterface

// ===== src/bsb_front.sv =====
// ----------------------------------------------------------------------------
// Bit-set bank front end
// Accepts request transactions, checks their ranges and turns each into a
// classified command for the command queue.
// ----------------------------------------------------------------------------
module bsb_front (
  bsb_req_if.sink         in_req,
  input  logic            q_full,
  output logic            q_push,
  output bsb_pkg::cmd_t   q_cmd
);

  logic bad_set_a;
  logic bad_set_b;
  logic bad_index;

  assign in_req.ready = !q_full;
  assign q_push       = in_req.valid && !q_full;

  always_comb begin
    bad_set_a = int'(in_req.set_a) >= bsb_pkg::NUM_SETS;
    bad_set_b = int'(in_req.set_b) >= bsb_pkg::NUM_SETS;
    bad_index = int'(in_req.bit_index) >= bsb_pkg::BITS_PER_SET;

    q_cmd.set_a   = in_req.set_a;
    q_cmd.set_b   = in_req.set_b;
    q_cmd.word    = bsb_pkg::WORD_IDX_W'(in_req.bit_index >> bsb_pkg::BIT_POS_W);
    q_cmd.bit_pos = in_req.bit_index[bsb_pkg::BIT_POS_W-1:0];

    case (in_req.opcode)
      bsb_pkg::OP_SET: begin
        q_cmd.kind = bsb_pkg::CMD_SET;
      end
      bsb_pkg::OP_CLEAR: begin
        q_cmd.kind = bsb_pkg::CMD_CLEAR;
      end
      bsb_pkg::OP_TEST: begin
        q_cmd.kind = bsb_pkg::CMD_TEST;
      end
      bsb_pkg::OP_FIND_LOW: begin
        q_cmd.kind = bsb_pkg::CMD_FIND_LOW;
      end
      bsb_pkg::OP_FIND_HIGH: begin
        q_cmd.kind = bsb_pkg::CMD_FIND_HIGH;
      end
      bsb_pkg::OP_DISJOINT: begin
        q_cmd.kind = bsb_pkg::CMD_DISJOINT;
      end
      default: begin
        q_cmd.kind = bsb_pkg::CMD_REJECT;
      end
    endcase

    // Single-bit operations need an index inside the set; the disjoint check
    // also needs a valid second set.
    if (bad_set_a ||
        (bad_index && q_cmd.kind inside {bsb_pkg::CMD_SET, bsb_pkg::CMD_CLEAR,
                                         bsb_pkg::CMD_TEST}) ||
        (bad_set_b && q_cmd.kind == bsb_pkg::CMD_DISJOINT)) begin
      q_cmd.kind = bsb_pkg::CMD_REJECT;
    end
  end

endmodule

// ===== src/bsb_queue.sv =====
// ----------------------------------------------------------------------------
// Bit-set bank command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bsb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bsb_pkg::cmd_t   push_cmd,
  output logic            full,
  input  logic            pop,
  output bsb_pkg::cmd_t   pop_cmd,
  output logic            empty
);

  localparam int PTR_W = (bsb_pkg::QUEUE_DEPTH > 1) ? $clog2(bsb_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(bsb_pkg::QUEUE_DEPTH + 1);

  bsb_pkg::cmd_t    entry_r [bsb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = count_r == CNT_W'(bsb_pkg::QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign pop_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(bsb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(bsb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(bsb_pkg::QUEUE_DEPTH))
    else $error("command queue holds more entries than its depth");
`endif

endmodule

// ===== src/bsb_back.sv =====
// ----------------------------------------------------------------------------
// Bit-set bank back end
// Executes classified commands against the word memory and registers one
// response transaction per command.
// ----------------------------------------------------------------------------
module bsb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  bsb_pkg::cmd_t   q_cmd,
  output logic            q_pop,
  bsb_rsp_if.source       out_rsp
);

  localparam int WB = bsb_pkg::WORD_BITS;
  localparam int WI = bsb_pkg::WORD_IDX_W;
  localparam int AW = bsb_pkg::ADDR_W;

  bsb_pkg::back_state_t state_r, state_nxt;
  bsb_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [WI-1:0]        cnt_r, cnt_nxt;

  // Word memory; entries never written read as zero through the valid bits.
  logic [WB-1:0]                   mem [bsb_pkg::TOTAL_WORDS];
  logic [bsb_pkg::TOTAL_WORDS-1:0] valid_r;
  logic [WB-1:0]                   rdata_a_r, rdata_b_r;
  logic                            rvld_a_r, rvld_b_r;
  logic [WB-1:0]                   word_a, word_b;

  logic [AW-1:0]  rd_addr_a, rd_addr_b, wr_addr;
  logic [WB-1:0]  wr_data, bit_mask;
  logic           wr_en;
  logic [WI-1:0]  start_word, next_word, rd_word;
  logic           last_word, hit;

  logic                     slot_free;
  logic                     res_load;
  logic                     res_flag, res_found, res_error;
  logic [bsb_pkg::POS_W-1:0] res_position;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_flag_r, out_found_r, out_error_r;
  logic [bsb_pkg::POS_W-1:0] out_position_r;

  assign word_a    = rvld_a_r ? rdata_a_r : '0;
  assign word_b    = rvld_b_r ? rdata_b_r : '0;
  assign slot_free = !out_valid_r || out_rsp.ready;
  assign bit_mask  = WB'(1) << cmd_r.bit_pos;

  always_comb begin
    case (q_cmd.kind)
      bsb_pkg::CMD_FIND_HIGH: start_word = WI'(bsb_pkg::WORDS_PER_SET - 1);
      bsb_pkg::CMD_FIND_LOW,
      bsb_pkg::CMD_DISJOINT:  start_word = '0;
      default:                start_word = q_cmd.word;
    endcase
  end

  assign next_word = (cmd_r.kind == bsb_pkg::CMD_FIND_HIGH) ? cnt_r - WI'(1)
                                                            : cnt_r + WI'(1);
  assign last_word = (cmd_r.kind == bsb_pkg::CMD_FIND_HIGH)
                     ? (cnt_r == '0)
                     : (cnt_r == WI'(bsb_pkg::WORDS_PER_SET - 1));
  assign hit       = (cmd_r.kind == bsb_pkg::CMD_DISJOINT) ? ((word_a & word_b) != '0)
                                                           : (word_a != '0);

  // The read for the first word goes out while the command is popped; each
  // scan cycle then prefetches the following word.
  assign rd_word   = (state_r == bsb_pkg::ST_IDLE) ? start_word : next_word;
  assign rd_addr_a = bsb_pkg::word_addr((state_r == bsb_pkg::ST_IDLE) ? q_cmd.set_a
                                                                      : cmd_r.set_a,
                                        rd_word);
  assign rd_addr_b = bsb_pkg::word_addr((state_r == bsb_pkg::ST_IDLE) ? q_cmd.set_b
                                                                      : cmd_r.set_b,
                                        rd_word);

  assign wr_addr = bsb_pkg::word_addr(cmd_r.set_a, cmd_r.word);
  assign wr_data = (cmd_r.kind == bsb_pkg::CMD_SET) ? (word_a | bit_mask)
                                                    : (word_a & ~bit_mask);
  assign wr_en   = (state_r == bsb_pkg::ST_ACCESS) &&
                   (cmd_r.kind == bsb_pkg::CMD_SET || cmd_r.kind == bsb_pkg::CMD_CLEAR);

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    q_pop        = 1'b0;
    res_load     = 1'b0;
    res_flag     = 1'b0;
    res_found    = 1'b0;
    res_error    = 1'b0;
    res_position = '0;
    case (state_r)
      bsb_pkg::ST_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          cnt_nxt = start_word;
          if (q_cmd.kind == bsb_pkg::CMD_REJECT) begin
            res_load  = 1'b1;
            res_error = 1'b1;
          end else if (q_cmd.kind inside {bsb_pkg::CMD_SET, bsb_pkg::CMD_CLEAR,
                                          bsb_pkg::CMD_TEST}) begin
            state_nxt = bsb_pkg::ST_ACCESS;
          end else begin
            state_nxt = bsb_pkg::ST_SCAN;
          end
        end
      end
      bsb_pkg::ST_ACCESS: begin
        res_load  = 1'b1;
        res_flag  = (cmd_r.kind == bsb_pkg::CMD_TEST) && ((word_a & bit_mask) != '0);
        state_nxt = bsb_pkg::ST_IDLE;
      end
      bsb_pkg::ST_SCAN: begin
        if (hit) begin
          res_load  = 1'b1;
          state_nxt = bsb_pkg::ST_IDLE;
          if (cmd_r.kind == bsb_pkg::CMD_FIND_LOW) begin
            res_found    = 1'b1;
            res_position = bsb_pkg::POS_W'(int'(cnt_r) * WB +
                                           int'(bsb_pkg::lowest_set(word_a)));
          end else if (cmd_r.kind == bsb_pkg::CMD_FIND_HIGH) begin
            res_found    = 1'b1;
            res_position = bsb_pkg::POS_W'(int'(cnt_r) * WB +
                                           int'(bsb_pkg::highest_set(word_a)));
          end
        end else if (last_word) begin
          res_load  = 1'b1;
          res_flag  = cmd_r.kind == bsb_pkg::CMD_DISJOINT;
          state_nxt = bsb_pkg::ST_IDLE;
        end else begin
          cnt_nxt = next_word;
        end
      end
      default: begin
        state_nxt = bsb_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = res_load || (out_valid_r && !out_rsp.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    cnt_r <= cnt_nxt;
    if (res_load) begin
      out_flag_r     <= res_flag;
      out_found_r    <= res_found;
      out_error_r    <= res_error;
      out_position_r <= res_position;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_a_r <= mem[rd_addr_a];
    rdata_b_r <= mem[rd_addr_b];
    rvld_a_r  <= valid_r[rd_addr_a];
    rvld_b_r  <= valid_r[rd_addr_b];
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.flag     = out_flag_r;
  assign out_rsp.found    = out_found_r;
  assign out_rsp.error    = out_error_r;
  assign out_rsp.position = out_position_r;

`ifndef SYNTHESIS
  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == bsb_pkg::ST_IDLE)
    else $error("command taken while another is in progress");
  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_rsp.ready))
    else $error("response register overwritten before it was taken");
  a_write_in_access: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == bsb_pkg::ST_ACCESS &&
               (cmd_r.kind == bsb_pkg::CMD_SET || cmd_r.kind == bsb_pkg::CMD_CLEAR)))
    else $error("memory written outside a set or clear access");
  a_result_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> state_r == bsb_pkg::ST_IDLE)
    else $error("back end did not return to idle after a response");
`endif

endmodule

// ===== src/bitset_bank_with_find_first_last.sv =====
// ----------------------------------------------------------------------------
// Bit-set bank with find-first/find-last
// Four bit sets of sixteen 64-bit words each, with set, clear, test, find
// lowest, find highest and disjoint-check operations.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake      Payload
//  in_req    sink       valid / ready  opcode, set_a, set_b, bit_index
//  out_rsp   source     valid / ready  flag, found, position, error
//
// In the back end, set, clear and test pass through the pop with memory read,
// the access state (read-modify-write for set and clear) and the response
// register; a rejected request passes through the pop with response load and
// the response register. Find and disjoint read one word per cycle from the
// word memory, scan at most WORDS_PER_SET words and stop early at the first hit.
// Reset is synchronous and active low; it clears the control state and the
// per-word valid bits, so every set reads as empty right after reset.
// The two-entry command queue keeps accepting requests while the back end
// works or while a response waits on out_rsp; a full queue drops in_req.ready.
//
module bitset_bank_with_find_first_last (
  input  logic        clk,
  input  logic        rst_n,
  bsb_req_if.sink     in_req,
  bsb_rsp_if.source   out_rsp
);

  // Front end to queue.
  logic          q_push;
  logic          q_full;
  bsb_pkg::cmd_t q_push_cmd;

  // Queue to back end.
  logic          q_pop;
  logic          q_empty;
  bsb_pkg::cmd_t q_pop_cmd;

  // The front end range-checks each request transaction and classifies it;
  // out-of-range requests travel on as reject commands so that responses stay
  // in request order.
  bsb_front u_front (
    .in_req (in_req),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  bsb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .empty    (q_empty)
  );

  // The back end owns the word memory and the response register. It takes a
  // new command only when the response register will be free, so a finished
  // result never has to wait inside the back end.
  bsb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (q_pop_cmd),
    .q_pop   (q_pop),
    .out_rsp (out_rsp)
  );

endmodule
